// File: hdl/uirb_pkg.sv
// Shared types and codes for the UART interrupt ring buffer block.
// Used by the ring module and the top level.
package uirb_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_SERVICE = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] host_byte;
    logic       line_data_ready;
    logic       line_tx_empty;
    logic [7:0] received_byte;
  } req_item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] read_byte;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       received_taken;
    logic       rx_irq_enable;
    logic       tx_irq_enable;
    logic       rx_has_data;
    logic       tx_has_room;
  } rsp_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

// File: hdl/uirb_chan_if.sv
// Valid/ready channel carrying one item of type T.
// No dependencies; payload types come from uirb_pkg at instantiation.
interface uirb_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/uirb_ring.sv
// One byte ring: storage array, head and tail pointers with wrap bits.
// Read data is registered on pop. Depends on uirb_pkg.
module uirb_ring #(
  parameter int RING_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  uirb_pkg::ring_ctl_t ctl,
  input  logic [7:0]          wdata,
  output uirb_pkg::ring_stat_t stat,
  output logic [7:0]          rdata
);
  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(RING_DEPTH - 1);

  logic [7:0]        mem [RING_DEPTH];
  logic [ADDR_W-1:0] head;
  logic              head_wrap;
  logic [ADDR_W-1:0] tail;
  logic              tail_wrap;

  assign stat.empty = (head == tail) && (head_wrap == tail_wrap);
  assign stat.full  = (head == tail) && (head_wrap != tail_wrap);

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      head_wrap <= 1'b0;
      tail      <= '0;
      tail_wrap <= 1'b0;
    end else begin
      if (ctl.push) begin
        if (tail == LAST) begin
          tail      <= '0;
          tail_wrap <= ~tail_wrap;
        end else begin
          tail <= tail + 1'b1;
        end
      end
      if (ctl.pop) begin
        if (head == LAST) begin
          head      <= '0;
          head_wrap <= ~head_wrap;
        end else begin
          head <= head + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wdata;
    end
    if (ctl.pop) begin
      rdata <= mem[head];
    end
  end

endmodule

// File: hdl/uart_interrupt_ring_buffers_top.sv
// UART receive and transmit ring buffers with interrupt enable bits.
// Depends on uirb_pkg, uirb_chan_if and uirb_ring.
//
// Usage: items arrive on req (host write, host read or interrupt service)
// and each produces exactly one result on rsp, in order. A host write
// queues host_byte for transmission; a host read returns the oldest
// received byte; a service item moves received_byte into the receive ring
// when line_data_ready is set, and the oldest queued byte out on send_byte
// when line_tx_empty is set. A refused host item (ring full or empty)
// returns accepted = 0 and changes nothing. The result is registered.
// Throughput: one item per cycle; each item does one ring access per ring
// and a pointer update, and ring reads come from a registered array port.
// Reset: both rings empty, receive enable set, transmit enable clear. Ring
// contents are not cleared; no pass over the storage is needed.
// Stall: the result register holds while rsp.ready is low, and req.ready
// drops until the result is taken; the result leaves the same cycle a new
// item enters.
module uart_interrupt_ring_buffers_top #(
  parameter int RING_DEPTH = 64
) (
  input logic clk,
  input logic rst,
  uirb_chan_if.sink   req,
  uirb_chan_if.source rsp
);
  uirb_pkg::ring_ctl_t  rx_ctl;
  uirb_pkg::ring_ctl_t  tx_ctl;
  uirb_pkg::ring_stat_t rx_stat;
  uirb_pkg::ring_stat_t tx_stat;
  logic [7:0]           rx_rdata;
  logic [7:0]           tx_rdata;

  logic fire;
  logic out_valid;
  logic accepted;
  logic accepted_next;
  logic read_sel;
  logic send_valid;
  logic taken;
  logic rx_en;
  logic rx_en_next;
  logic tx_en;
  logic tx_en_next;

  assign req.ready = ~rst & (~out_valid | rsp.ready);
  assign fire      = req.valid & req.ready;

  always_comb begin
    rx_ctl        = '0;
    tx_ctl        = '0;
    accepted_next = 1'b0;
    rx_en_next    = rx_en;
    tx_en_next    = tx_en;
    case (req.data.operation)
      uirb_pkg::OP_WRITE: begin
        if (!tx_stat.full) begin
          tx_ctl.push   = 1'b1;
          tx_en_next    = 1'b1;
          accepted_next = 1'b1;
        end
      end
      uirb_pkg::OP_READ: begin
        if (!rx_stat.empty) begin
          rx_ctl.pop    = 1'b1;
          rx_en_next    = 1'b1;
          accepted_next = 1'b1;
        end
      end
      uirb_pkg::OP_SERVICE: begin
        if (rx_stat.full) begin
          rx_en_next = 1'b0;
        end else begin
          rx_ctl.push = req.data.line_data_ready;
        end
        if (tx_stat.empty) begin
          tx_en_next = 1'b0;
        end else begin
          tx_ctl.pop = req.data.line_tx_empty;
        end
      end
      default: begin
      end
    endcase
    if (!fire) begin
      rx_ctl = '0;
      tx_ctl = '0;
    end
  end

  uirb_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rx_ctl),
    .wdata (req.data.received_byte),
    .stat  (rx_stat),
    .rdata (rx_rdata)
  );

  uirb_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tx_ctl),
    .wdata (req.data.host_byte),
    .stat  (tx_stat),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      accepted   <= 1'b0;
      read_sel   <= 1'b0;
      send_valid <= 1'b0;
      taken      <= 1'b0;
      rx_en      <= 1'b1;
      tx_en      <= 1'b0;
    end else if (fire) begin
      out_valid  <= 1'b1;
      accepted   <= accepted_next;
      read_sel   <= rx_ctl.pop;
      send_valid <= tx_ctl.pop;
      taken      <= rx_ctl.push & (req.data.operation == uirb_pkg::OP_SERVICE);
      rx_en      <= rx_en_next;
      tx_en      <= tx_en_next;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid               = out_valid;
  assign rsp.data.accepted       = accepted;
  assign rsp.data.read_byte      = read_sel ? rx_rdata : 8'd0;
  assign rsp.data.send_valid     = send_valid;
  assign rsp.data.send_byte      = send_valid ? tx_rdata : 8'd0;
  assign rsp.data.received_taken = taken;
  assign rsp.data.rx_irq_enable  = rx_en;
  assign rsp.data.tx_irq_enable  = tx_en;
  assign rsp.data.rx_has_data    = ~rx_stat.empty;
  assign rsp.data.tx_has_room    = ~tx_stat.full;

endmodule
